// File: rtl/stb_pkg.sv
// Shared types and constants for the sorted key/value table with binary search.
// Used by stb_front, stb_back and the top level sorted_table_binary_search.
`default_nettype none

package stb_pkg;

  // Table geometry.
  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = AddrW + 1;

  // Field widths.
  localparam int DataW = 32;
  localparam int ActW  = 2;

  // Command queue between the front and the back.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Action codes on the input channel.
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ActW-1:0] ACT_APPEND = 2'd1;
  localparam logic [ActW-1:0] ACT_LOOKUP = 2'd2;

  // Decoded operation carried to the back.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_LOOKUP
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/stb_front.sv
// Front end: accepts input transactions, decodes the action and holds a
// short command queue for the back end. Depends on stb_pkg.
`default_nettype none

module stb_front import stb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [DataW-1:0] item_key_i,
  input  logic signed [DataW-1:0] item_value_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output cmd_t                    cmd_o
);

  cmd_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] q_cnt_q;
  logic             do_push, do_pop;
  cmd_t             cmd_in;

  // Decode the action; the reserved code becomes a no-op.
  always_comb begin
    cmd_in.key   = item_key_i;
    cmd_in.value = item_value_i;
    unique case (action_i)
      ACT_CLEAR:  cmd_in.op = OP_CLEAR;
      ACT_APPEND: cmd_in.op = OP_APPEND;
      ACT_LOOKUP: cmd_in.op = OP_LOOKUP;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign full        = (q_cnt_q == QCntW'(QDepth));
  assign cmd_valid_o = (q_cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        q_cnt_q <= q_cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        q_cnt_q <= q_cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/stb_back.sv
// Back end: owns the key and value memories and the entry count, carries out
// clear, append and binary-search lookup, and holds the result register.
// Depends on stb_pkg.
`default_nettype none

module stb_back import stb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  cmd_t                    cmd_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    found_o,
  output logic signed [DataW-1:0] found_value_o,
  output logic                    table_full_error_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         first_q, first_d, last_q, last_d, mid_q, mid_d;
  logic [CntW-1:0]         span, mid;
  logic signed [DataW-1:0] key_q, key_d;
  logic                    res_found_q, res_found_d, res_err_q, res_err_d;
  logic signed [DataW-1:0] res_val_q, res_val_d;
  logic                    out_valid_q, out_valid_d, out_load;

  logic signed [DataW-1:0] key_mem [TableDepth];
  logic signed [DataW-1:0] val_mem [TableDepth];
  logic signed [DataW-1:0] key_rd_q, val_rd_q;
  logic                    mem_we;
  logic [AddrW-1:0]        rd_addr;

  // Current search window and its midpoint.
  assign span = last_q - first_q;
  assign mid  = first_q + (span >> 1);

  // Probe the midpoint while the window holds more than one entry.
  assign rd_addr = (span > CntW'(1)) ? mid[AddrW-1:0] : first_q[AddrW-1:0];

  // Memories: one write port for append, one registered read port for search.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[count_q[AddrW-1:0]] <= cmd_i.key;
      val_mem[count_q[AddrW-1:0]] <= cmd_i.value;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    first_d     = first_q;
    last_d      = last_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_val_d   = res_val_q;
    res_err_d   = res_err_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          key_d       = cmd_i.key;
          res_found_d = 1'b0;
          res_val_d   = '0;
          res_err_d   = 1'b0;
          state_d     = S_RESULT;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (count_q == CntW'(TableDepth)) begin
                res_err_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_LOOKUP: begin
              first_d = '0;
              last_d  = count_q;
              state_d = S_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // The read at rd_addr is issued this cycle.
        if (span > CntW'(1)) begin
          mid_d   = mid;
          state_d = S_CMP;
        end else if (span == CntW'(1)) begin
          state_d = S_FINAL;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_CMP: begin
        // Keep the upper half unless the key is below the middle key.
        if (key_q < key_rd_q) begin
          last_d = mid_q;
        end else begin
          first_d = mid_q;
        end
        state_d = S_SEARCH;
      end
      S_FINAL: begin
        if (key_rd_q == key_q) begin
          res_found_d = 1'b1;
          res_val_d   = val_rd_q;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Search window, key and pending result.
  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    last_q      <= last_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_val_q   <= res_val_d;
    res_err_q   <= res_err_d;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_o            <= res_found_q;
      found_value_o      <= res_val_q;
      table_full_error_o <= res_err_q;
    end
  end

  assign empty = !out_valid_q;

endmodule

`default_nettype wire

// File: rtl/sorted_table_binary_search.sv
// Sorted key/value table with binary-search lookup: top level.
// Input transactions carry an action (clear, append or lookup), a signed key
// and a signed value; push is taken when full is low.
// Results leave through a queue-style port: while empty is low, found,
// found_value and table_full_error hold the oldest result, taken when pop is
// high. Every input transaction gives exactly one result transaction.
// A two-entry command queue separates the input decoder from the executor,
// so input keeps flowing while a search runs or a result waits.
// Clear, append and the reserved action take two executor cycles; a lookup
// over n entries takes at most 2*ceil(log2(n)) + 4 cycles (three on an empty
// table), 24 for a full table of 1024, set by the one registered read port
// that each probe must wait on.
// With the executor idle, empty falls the execution time after the push edge.
// When pop stays low, the result register holds, the executor finishes the
// next item and waits, and full rises once the command queue fills.
// Reset empties the table and both queues; the memories are not cleared.
// Keys must be appended in ascending order for lookups to be exact.
`default_nettype none

module sorted_table_binary_search import stb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [DataW-1:0] item_key_i,
  input  logic signed [DataW-1:0] item_value_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    found_o,
  output logic signed [DataW-1:0] found_value_o,
  output logic                    table_full_error_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Decoder and command queue.
  stb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .item_key_i   (item_key_i),
    .item_value_i (item_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // Table storage, search sequencer and result register.
  stb_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (cmd_valid),
    .cmd_ready_o        (cmd_ready),
    .cmd_i              (cmd),
    .empty              (empty),
    .pop                (pop),
    .found_o            (found_o),
    .found_value_o      (found_value_o),
    .table_full_error_o (table_full_error_o)
  );

`ifndef SYNTH
  // A dropped append never reports a hit.
  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(found_o && table_full_error_o))
    else $error("hit and full error reported together");

  // A miss reports a zero value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (found_value_o == '0))
    else $error("nonzero value on a miss");

  // A full command queue always offers a command to the executor.
  a_full_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("queue full but no command offered");

  // The executor never takes commands in consecutive cycles.
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> !(cmd_valid && cmd_ready))
    else $error("commands taken in consecutive cycles");
`endif

endmodule

`default_nettype wire
